>>> rtl/pcmmix_pkg.sv
// Shared types, constants and lookup functions for the four-channel PCM mixer.
// No dependencies; the top level, controller, datapath, divider and testbench import this package.
package pcmmix_pkg;

  localparam int CHANNELS      = 4;
  localparam int CH_W          = 2;
  localparam int FRAC_BITS     = 16;
  localparam int ROM_DEPTH_DEF = 65536;

  localparam int CLK_W   = 26;
  localparam int SR_W    = 18;
  localparam int ROMSZ_W = 17;
  localparam int CFG_W   = 26;
  localparam int NUM_W   = CLK_W + FRAC_BITS;
  localparam int DEN_W   = 31;

  localparam logic [CLK_W-1:0] CLK_DEFAULT = 26'd3579545;
  localparam logic [SR_W-1:0]  SR_DEFAULT  = 18'd44100;

  // Sound-side register offsets.
  localparam logic [5:0] RA_PORT1    = 6'h01;
  localparam logic [5:0] RA_CH_FIRST = 6'h08;
  localparam logic [5:0] RA_KEYON    = 6'h28;
  localparam logic [5:0] RA_STATUS   = 6'h29;
  localparam logic [5:0] RA_LOOP     = 6'h2a;
  localparam logic [5:0] RA_PAN01    = 6'h2c;
  localparam logic [5:0] RA_PAN23    = 6'h2d;
  localparam logic [5:0] RA_ROMRD    = 6'h2e;
  localparam logic [5:0] RA_MODE     = 6'h2f;

  // Per-channel register slots within a block of eight.
  localparam logic [2:0] SUB_RATE_LO  = 3'd0;
  localparam logic [2:0] SUB_RATE_HI  = 3'd1;
  localparam logic [2:0] SUB_SIZE_LO  = 3'd2;
  localparam logic [2:0] SUB_SIZE_HI  = 3'd3;
  localparam logic [2:0] SUB_START_LO = 3'd4;
  localparam logic [2:0] SUB_START_MD = 3'd5;
  localparam logic [2:0] SUB_START_HI = 3'd6;

  typedef enum logic [2:0] {
    OP_REG_WR  = 3'd0,
    OP_REG_RD  = 3'd1,
    OP_MAIN_WR = 3'd2,
    OP_MAIN_RD = 3'd3,
    OP_ROM_LD  = 3'd4,
    OP_RENDER  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    CFG_CLOCK = 2'd0,
    CFG_SRATE = 2'd1,
    CFG_ROMSZ = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RB_WAIT,
    ST_RB_DONE,
    ST_CH_CHECK,
    ST_CH_ADDR,
    ST_CH_DIVS,
    ST_CH_DIV,
    ST_CH_MIX1,
    ST_CH_MIX2,
    ST_FIN1,
    ST_FIN2,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    DC_NONE,
    DC_LOAD,
    DC_REG_WR,
    DC_REG_RD,
    DC_PORT_WR,
    DC_PORT_RD,
    DC_ROM_LD,
    DC_RB_ADDR,
    DC_RB_DONE,
    DC_CH_CHECK,
    DC_CH_ADDR,
    DC_DIV_START,
    DC_MIX1,
    DC_MIX2,
    DC_FIN1,
    DC_FIN2
  } dp_op_t;

  typedef struct packed {
    dp_op_t          op;
    logic [CH_W-1:0] chan;
    logic            bypass;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       rb_go;
    logic       render_go;
    logic       ch_live;
    logic       div_busy;
  } dp_stat_t;

  function automatic logic [8:0] pan_left_w(input logic [2:0] p);
    case (p)
      3'd1:    pan_left_w = 9'd256;
      3'd2:    pan_left_w = 9'd234;
      3'd3:    pan_left_w = 9'd210;
      3'd4:    pan_left_w = 9'd181;
      3'd5:    pan_left_w = 9'd148;
      3'd6:    pan_left_w = 9'd104;
      default: pan_left_w = 9'd0;
    endcase
  endfunction

  function automatic logic [8:0] pan_right_w(input logic [2:0] p);
    case (p)
      3'd2:    pan_right_w = 9'd104;
      3'd3:    pan_right_w = 9'd148;
      3'd4:    pan_right_w = 9'd181;
      3'd5:    pan_right_w = 9'd210;
      3'd6:    pan_right_w = 9'd234;
      3'd7:    pan_right_w = 9'd256;
      default: pan_right_w = 9'd0;
    endcase
  endfunction

endpackage

>>> rtl/pcmmix_if.sv
// Valid/ready channel interfaces for commands into and results out of the mixer.
// Depends on nothing but plain logic types.
interface pcmmix_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic [5:0]         reg_addr;
  logic [7:0]         data;
  logic [15:0]        rom_addr;
  logic signed [15:0] mix_left;
  logic signed [15:0] mix_right;
  logic [12:0]        gain;

  modport source (output valid, op, reg_addr, data, rom_addr, mix_left, mix_right, gain,
                  input ready);
  modport sink (input valid, op, reg_addr, data, rom_addr, mix_left, mix_right, gain,
                output ready);
endinterface

interface pcmmix_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         read_data;
  logic signed [15:0] out_left;
  logic signed [15:0] out_right;

  modport source (output valid, read_data, out_left, out_right, input ready);
  modport sink (input valid, read_data, out_left, out_right, output ready);
endinterface

>>> rtl/four_channel_pcm_sample_mixer_unit.sv
// Top level of the four-channel PCM sample mixer: controller, datapath and result register.
// Depends on pcmmix_pkg, pcmmix_if, pcmmix_ctrl and pcmmix_dp.
//
// Every input transaction yields exactly one result transaction. Register, port
// and ROM-load transactions go from dispatch straight to the done state; a ROM
// read-back through offset 0x2e also passes RB_WAIT and RB_DONE. A render with
// mode bit 1 set and a non-zero ROM size walks the four channels in turn: an idle
// channel is only checked, a playing one is addressed, run through the restoring
// pitch divider (one bit of the 42-bit quotient per cycle) and mixed; ST_FIN1 and
// ST_FIN2 then apply gain and saturate. Else the mix inputs pass through. One
// transaction is processed at a time, while a finished result waits in the output
// register the next transaction is already accepted. The sample ROM has no reset
// and no clearing pass: reading a byte that was never loaded returns an undefined
// value. Configuration is taken on any cycle with cfg_we high, but must only be
// written while the block is idle.
module four_channel_pcm_sample_mixer_unit
  import pcmmix_pkg::*;
#(
  parameter int ROM_DEPTH = ROM_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  pcmmix_in_if.sink        in_ch,
  pcmmix_out_if.source     out_ch,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic               res_push;
  logic               res_free;
  logic [7:0]         res_read_data;
  logic signed [15:0] res_left, res_right;

  logic               out_valid_r;
  logic [7:0]         out_rd_r;
  logic signed [15:0] out_l_r, out_r_r;

  // The result register is free when empty or when its transaction completes now.
  assign res_free = !out_valid_r || out_ch.ready;

  pcmmix_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .res_free (res_free),
    .res_push (res_push),
    .stat     (stat),
    .cmd      (cmd)
  );

  pcmmix_dp #(.ROM_DEPTH(ROM_DEPTH)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_op         (in_ch.op),
    .in_reg_addr   (in_ch.reg_addr),
    .in_data       (in_ch.data),
    .in_rom_addr   (in_ch.rom_addr),
    .in_mix_left   (in_ch.mix_left),
    .in_mix_right  (in_ch.mix_right),
    .in_gain       (in_ch.gain),
    .res_read_data (res_read_data),
    .res_left      (res_left),
    .res_right     (res_right)
  );

  // Output register: holds one finished result until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_push) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_push) begin
      out_rd_r <= res_read_data;
      out_l_r  <= res_left;
      out_r_r  <= res_right;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_rd_r;
  assign out_ch.out_left  = out_l_r;
  assign out_ch.out_right = out_r_r;

endmodule

>>> rtl/pcmmix_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcmmix_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q <= mem[raddr];
    end
  end

endmodule

>>> rtl/pcmmix_div.sv
// Restoring divider for the pitch step, one quotient bit per cycle.
// Depends on pcmmix_pkg for the operand widths.
module pcmmix_div
  import pcmmix_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [31:0]      step
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  always_comb begin
    rem_sh   = {rem_r[DEN_W-1:0], num_r[NUM_W-1]};
    fits     = rem_sh >= {1'b0, den_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = num;
      quo_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      num_nxt = {num_r[NUM_W-2:0], 1'b0};
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      rem_nxt = fits ? rem_sh - {1'b0, den_r} : rem_sh;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  // The step is at least one and saturates at the top of 32 bits.
  always_comb begin
    if (quo_r == '0) begin
      step = 32'd1;
    end else if (|quo_r[NUM_W-1:32]) begin
      step = 32'hFFFF_FFFF;
    end else begin
      step = quo_r[31:0];
    end
  end

  assign busy = busy_r;

endmodule

>>> rtl/pcmmix_dp.sv
// Datapath: register file, channel state, sample ROM, pitch divider and mix arithmetic.
// Depends on pcmmix_pkg, pcmmix_ram and pcmmix_div.
module pcmmix_dp
  import pcmmix_pkg::*;
#(
  parameter int ROM_DEPTH = ROM_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic [2:0]         in_op,
  input  logic [5:0]         in_reg_addr,
  input  logic [7:0]         in_data,
  input  logic [15:0]        in_rom_addr,
  input  logic signed [15:0] in_mix_left,
  input  logic signed [15:0] in_mix_right,
  input  logic [12:0]        in_gain,
  output logic [7:0]         res_read_data,
  output logic signed [15:0] res_left,
  output logic signed [15:0] res_right
);

  localparam int AW = $clog2(ROM_DEPTH);

  // Configuration.
  logic [CLK_W-1:0]   clk_hz_r;
  logic [SR_W-1:0]    srate_r;
  logic [ROMSZ_W-1:0] romsz_r;

  // Latched item.
  logic [2:0]         op_r;
  logic [5:0]         ra_r;
  logic [7:0]         data_r;
  logic [15:0]        rom_addr_r;
  logic signed [15:0] mixl_r, mixr_r;
  logic [12:0]        gain_r;

  // Chip state.
  logic [7:0]          comm_r [4];
  logic [2:0]          mode_r;
  logic [7:0]          keyon_r;
  logic [11:0]         rate_r  [CHANNELS];
  logic [15:0]         size_r  [CHANNELS];
  logic [20:0]         start_r [CHANNELS];
  logic [6:0]          vol_r   [CHANNELS];
  logic [2:0]          pan_r   [CHANNELS];
  logic [31:0]         pos_r   [CHANNELS];
  logic [CHANNELS-1:0] play_r, loop_r, ppcm_r, rev_r;

  // Working registers.
  logic                  av_r;
  logic [DEN_W-1:0]      den_r;
  logic signed [15:0]    p_r;
  logic signed [18:0]    accl_r, accr_r;
  logic signed [32:0]    gl_r, gr_r;
  logic [7:0]            rd_r;
  logic signed [15:0]    outl_r, outr_r;

  logic [CH_W-1:0]  ch;
  logic [15:0]      pos_hi;
  logic [21:0]      a_rb, a_fwd, a_ch;
  logic             rev_ok;
  logic             a_rb_ok, a_ch_ok;
  logic [CLK_W-1:0] clk_eff;
  logic [SR_W-1:0]  sr_eff;
  logic [12:0]      span;
  logic [5:0]       roff;
  logic [CH_W-1:0]  rch;
  logic [2:0]       rsub;
  logic [7:0]       rising;
  logic [7:0]       status;
  logic [7:0]       ram_q;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_raddr;
  logic             div_start, div_busy;
  logic [31:0]      div_step;
  logic signed [15:0] p_nxt;
  logic signed [25:0] prod_l, prod_r;
  logic signed [17:0] cont_l, cont_r;
  logic signed [32:0] adj_l, adj_r;
  logic signed [25:0] sum_l, sum_r;

  function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
    if (v > 26'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -26'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  always_comb begin
    ch      = cmd.chan;
    clk_eff = (clk_hz_r == '0) ? CLK_DEFAULT : clk_hz_r;
    sr_eff  = (srate_r == '0) ? SR_DEFAULT : srate_r;
    span    = 13'd4096 - {1'b0, rate_r[ch]};
    pos_hi  = pos_r[ch][31:16];
    a_rb    = {1'b0, start_r[0]} + {6'd0, pos_r[0][31:16]};
    a_fwd   = {1'b0, start_r[ch]} + {6'd0, pos_hi};
    rev_ok  = {1'b0, start_r[ch]} >= {6'd0, pos_hi};
    a_ch    = rev_r[ch] ? ({1'b0, start_r[ch]} - {6'd0, pos_hi}) : a_fwd;
    a_rb_ok = (32'(a_rb) < 32'(romsz_r)) && (32'(a_rb) < 32'(ROM_DEPTH));
    a_ch_ok = (!rev_r[ch] || rev_ok) && (32'(a_ch) < 32'(romsz_r))
              && (32'(a_ch) < 32'(ROM_DEPTH));
    roff    = ra_r - RA_CH_FIRST;
    rch     = roff[4:3];
    rsub    = roff[2:0];
    rising  = data_r & ~keyon_r;
    status  = {4'd0, play_r};
    ram_we  = (cmd.op == DC_ROM_LD) && (32'(rom_addr_r) < 32'(ROM_DEPTH));
    ram_re  = (cmd.op == DC_RB_ADDR) || (cmd.op == DC_CH_ADDR);
    ram_raddr = (cmd.op == DC_RB_ADDR) ? a_rb[AW-1:0] : a_ch[AW-1:0];
    div_start = cmd.op == DC_DIV_START;
    p_nxt   = 16'((av_r ? $signed(ram_q) : 8'sd0) * $signed({1'b0, vol_r[ch]}));
    prod_l  = p_r * $signed({1'b0, pan_left_w(pan_r[ch])});
    prod_r  = p_r * $signed({1'b0, pan_right_w(pan_r[ch])});
    cont_l  = prod_l[25:8];
    cont_r  = prod_r[25:8];
    adj_l   = gl_r + (gl_r[32] ? 33'sd255 : 33'sd0);
    adj_r   = gr_r + (gr_r[32] ? 33'sd255 : 33'sd0);
    sum_l   = 26'(mixl_r) + 26'($signed(adj_l[32:8]));
    sum_r   = 26'(mixr_r) + 26'($signed(adj_r[32:8]));
  end

  pcmmix_ram #(.WIDTH(8), .DEPTH(ROM_DEPTH)) u_rom (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(rom_addr_r)),
    .wdata (data_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .q     (ram_q)
  );

  pcmmix_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({clk_eff, {FRAC_BITS{1'b0}}}),
    .den   (den_r),
    .busy  (div_busy),
    .step  (div_step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= CLK_DEFAULT;
      srate_r  <= SR_DEFAULT;
      romsz_r  <= '0;
      for (int i = 0; i < 4; i++) begin
        comm_r[i] <= 8'hFF;
      end
      mode_r  <= '0;
      keyon_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        rate_r[i]  <= '0;
        size_r[i]  <= '0;
        start_r[i] <= '0;
        vol_r[i]   <= '0;
        pan_r[i]   <= '0;
        pos_r[i]   <= '0;
      end
      play_r <= '0;
      loop_r <= '0;
      ppcm_r <= '0;
      rev_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CLOCK: clk_hz_r <= cfg_wdata[CLK_W-1:0];
          CFG_SRATE: srate_r  <= cfg_wdata[SR_W-1:0];
          CFG_ROMSZ: romsz_r  <= cfg_wdata[ROMSZ_W-1:0];
          default: ;
        endcase
      end
      case (cmd.op)
        DC_REG_WR: begin
          if (ra_r == 6'h02 || ra_r == 6'h03) begin
            comm_r[ra_r[1:0]] <= data_r;
          end else if (ra_r == RA_KEYON) begin
            keyon_r <= data_r;
            for (int i = 0; i < CHANNELS; i++) begin
              rev_r[i] <= data_r[4+i];
              if (rising[i]) begin
                play_r[i] <= 1'b1;
                pos_r[i]  <= ppcm_r[i] ? (32'd1 << FRAC_BITS) : 32'd0;
              end else if (!data_r[i]) begin
                play_r[i] <= 1'b0;
              end
            end
          end else if (ra_r >= RA_CH_FIRST && ra_r < RA_KEYON) begin
            case (rsub)
              SUB_RATE_LO:  rate_r[rch][7:0]    <= data_r;
              SUB_RATE_HI:  rate_r[rch][11:8]   <= data_r[3:0];
              SUB_SIZE_LO:  size_r[rch][7:0]    <= data_r;
              SUB_SIZE_HI:  size_r[rch][15:8]   <= data_r;
              SUB_START_LO: start_r[rch][7:0]   <= data_r;
              SUB_START_MD: start_r[rch][15:8]  <= data_r;
              SUB_START_HI: start_r[rch][20:16] <= data_r[4:0];
              default:      vol_r[rch]          <= data_r[6:0];
            endcase
          end else if (ra_r == RA_LOOP) begin
            loop_r <= data_r[3:0];
            ppcm_r <= data_r[7:4];
          end else if (ra_r == RA_PAN01) begin
            pan_r[0] <= data_r[2:0];
            pan_r[1] <= data_r[5:3];
          end else if (ra_r == RA_PAN23) begin
            pan_r[2] <= data_r[2:0];
            pan_r[3] <= data_r[5:3];
          end else if (ra_r == RA_MODE) begin
            mode_r <= data_r[2:0];
          end
        end
        DC_REG_RD: begin
          if (ra_r <= RA_PORT1) begin
            comm_r[ra_r[1:0]] <= 8'hFF;
          end
        end
        DC_PORT_WR: comm_r[{1'b0, ra_r[0]}] <= data_r;
        DC_RB_ADDR: pos_r[0] <= pos_r[0] + (32'd1 << FRAC_BITS);
        DC_CH_CHECK: begin
          if (play_r[ch] && pos_hi >= size_r[ch]) begin
            if (loop_r[ch]) begin
              pos_r[ch] <= '0;
            end else begin
              play_r[ch] <= 1'b0;
            end
          end
        end
        DC_MIX2: pos_r[ch] <= pos_r[ch] + div_step;
        default: ;
      endcase
    end
  end

  // Item latch, results and arithmetic pipeline registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      DC_LOAD: begin
        op_r       <= in_op;
        ra_r       <= in_reg_addr;
        data_r     <= in_data;
        rom_addr_r <= in_rom_addr;
        mixl_r     <= in_mix_left;
        mixr_r     <= in_mix_right;
        gain_r     <= in_gain;
        rd_r       <= '0;
        outl_r     <= '0;
        outr_r     <= '0;
        accl_r     <= '0;
        accr_r     <= '0;
      end
      DC_REG_RD: begin
        if (ra_r <= RA_PORT1) begin
          rd_r <= comm_r[ra_r[1:0]];
        end else if (ra_r == RA_STATUS) begin
          rd_r <= status;
        end
      end
      DC_PORT_RD: rd_r <= comm_r[{1'b1, ra_r[0]}];
      DC_RB_ADDR: av_r <= a_rb_ok;
      DC_RB_DONE: rd_r <= av_r ? ram_q : 8'd0;
      DC_CH_ADDR: begin
        av_r  <= a_ch_ok;
        den_r <= DEN_W'(span * sr_eff);
      end
      DC_MIX1: p_r <= p_nxt;
      DC_MIX2: begin
        accl_r <= accl_r + 19'(cont_l);
        accr_r <= accr_r + 19'(cont_r);
      end
      DC_FIN1: begin
        gl_r <= accl_r * $signed({1'b0, gain_r});
        gr_r <= accr_r * $signed({1'b0, gain_r});
      end
      DC_FIN2: begin
        outl_r <= sat16(sum_l);
        outr_r <= sat16(sum_r);
      end
      default: ;
    endcase
    if (cmd.bypass) begin
      outl_r <= mixl_r;
      outr_r <= mixr_r;
    end
  end

  assign stat.op        = op_r;
  assign stat.rb_go     = (ra_r == RA_ROMRD) && mode_r[0] && (romsz_r != '0);
  assign stat.render_go = mode_r[1] && (romsz_r != '0);
  assign stat.ch_live   = play_r[ch] && ((pos_hi < size_r[ch]) || loop_r[ch]);
  assign stat.div_busy  = div_busy;

  assign res_read_data = rd_r;
  assign res_left      = outl_r;
  assign res_right     = outr_r;

endmodule

>>> rtl/pcmmix_ctrl.sv
// Controller state machine that sequences each transaction through the datapath.
// Depends on pcmmix_pkg for the state, command and status types.
module pcmmix_ctrl
  import pcmmix_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     res_free,
  output logic     res_push,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t          state_r, state_nxt;
  logic [CH_W-1:0] chan_r, chan_nxt;
  logic            last_ch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      chan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      chan_r  <= chan_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    chan_nxt   = chan_r;
    in_ready   = 1'b0;
    res_push   = 1'b0;
    cmd.op     = DC_NONE;
    cmd.chan   = chan_r;
    cmd.bypass = 1'b0;
    last_ch    = chan_r == CH_W'(CHANNELS - 1);
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = DC_LOAD;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_nxt = ST_DONE;
        unique case (stat.op)
          OP_REG_WR:  cmd.op = DC_REG_WR;
          OP_REG_RD: begin
            if (stat.rb_go) begin
              cmd.op    = DC_RB_ADDR;
              state_nxt = ST_RB_WAIT;
            end else begin
              cmd.op = DC_REG_RD;
            end
          end
          OP_MAIN_WR: cmd.op = DC_PORT_WR;
          OP_MAIN_RD: cmd.op = DC_PORT_RD;
          OP_ROM_LD:  cmd.op = DC_ROM_LD;
          OP_RENDER: begin
            if (stat.render_go) begin
              chan_nxt  = '0;
              state_nxt = ST_CH_CHECK;
            end else begin
              cmd.bypass = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_RB_WAIT: state_nxt = ST_RB_DONE;
      ST_RB_DONE: begin
        cmd.op    = DC_RB_DONE;
        state_nxt = ST_DONE;
      end
      ST_CH_CHECK: begin
        cmd.op = DC_CH_CHECK;
        if (stat.ch_live) begin
          state_nxt = ST_CH_ADDR;
        end else if (last_ch) begin
          state_nxt = ST_FIN1;
        end else begin
          chan_nxt = chan_r + 1'b1;
        end
      end
      ST_CH_ADDR: begin
        cmd.op    = DC_CH_ADDR;
        state_nxt = ST_CH_DIVS;
      end
      ST_CH_DIVS: begin
        cmd.op    = DC_DIV_START;
        state_nxt = ST_CH_DIV;
      end
      ST_CH_DIV: begin
        if (!stat.div_busy) begin
          state_nxt = ST_CH_MIX1;
        end
      end
      ST_CH_MIX1: begin
        cmd.op    = DC_MIX1;
        state_nxt = ST_CH_MIX2;
      end
      ST_CH_MIX2: begin
        cmd.op = DC_MIX2;
        if (last_ch) begin
          state_nxt = ST_FIN1;
        end else begin
          chan_nxt  = chan_r + 1'b1;
          state_nxt = ST_CH_CHECK;
        end
      end
      ST_FIN1: begin
        cmd.op    = DC_FIN1;
        state_nxt = ST_FIN2;
      end
      ST_FIN2: begin
        cmd.op    = DC_FIN2;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_free) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> tb/four_channel_pcm_sample_mixer_unit_test.sv
// Self-checking testbench for the four-channel PCM sample mixer: drives command
// transactions, predicts every result and compares it. Depends on pcmmix_pkg,
// the pcmmix_if channel interfaces and the four_channel_pcm_sample_mixer_unit RTL.
module four_channel_pcm_sample_mixer_unit_test
  import pcmmix_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Command codes with no meaning to the block; they must be ignored.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  // Register offsets not named in the package.
  localparam logic [5:0] RA_PORT0     = 6'h00;
  localparam logic [5:0] RA_SND_PORT2 = 6'h02;
  localparam logic [5:0] RA_SND_PORT3 = 6'h03;
  localparam logic [5:0] RA_HOLE      = 6'h04;
  localparam logic [2:0] SUB_VOLUME   = 3'd7;

  // Bit positions within the per-channel flag nibble.
  localparam int FL_PLAY = 0;
  localparam int FL_LOOP = 1;
  localparam int FL_PPCM = 2;
  localparam int FL_REV  = 3;

  localparam int ROM_FILL    = 128;
  localparam int PHASE_ITEMS = 230;
  localparam int HOLD_AFTER  = 300;
  localparam int HOLD_LEN    = 500;
  localparam int DRAIN_WAIT  = 400;
  localparam int CFG_QUIET   = 16;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [2:0]         op;
    logic [5:0]         reg_addr;
    logic [7:0]         data;
    logic [15:0]        rom_addr;
    logic signed [15:0] mix_left;
    logic signed [15:0] mix_right;
    logic [12:0]        gain;
  } mix_cmd_t;

  typedef struct packed {
    logic [7:0]         read_data;
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
  } mix_res_t;

  // One slot of the stimulus plan: either a configuration write or a command.
  typedef struct packed {
    bit          is_cfg;
    cfg_idx_t    cfg_sel;
    logic [25:0] cfg_val;
    mix_cmd_t    cmd;
    mix_res_t    res;
  } plan_slot_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  pcmmix_in_if  in_ch();
  pcmmix_out_if out_ch();

  four_channel_pcm_sample_mixer_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the mixer state, advanced as the plan is built.
  // ---------------------------------------------------------------------------
  logic [7:0]  rom_img    [65536];
  bit          rom_loaded [65536];
  logic [7:0]  port_q  [4];
  logic [2:0]  mode_q;
  logic [7:0]  keyon_q;
  logic [11:0] rate_q  [4];
  logic [15:0] size_q  [4];
  logic [20:0] start_q [4];
  logic [6:0]  vol_q   [4];
  logic [3:0]  flags_q [4];
  logic [2:0]  pan_q   [4];
  logic [31:0] pos_q   [4];
  logic [25:0] clk_hz_q;
  logic [17:0] srate_q;
  logic [16:0] romsz_q;
  bit          touched_blank;

  int left_weight  [8] = '{0, 256, 234, 210, 181, 148, 104, 0};
  int right_weight [8] = '{0, 0, 104, 148, 181, 210, 234, 256};

  plan_slot_t plan_q [$];
  mix_res_t   awaited_q [$];

  int errors = 0;
  int total_cmds = 0;
  int sent_cnt = 0;
  int results_cnt = 0;
  int renders_live = 0;
  int romreads_live = 0;
  int dropped_cmds = 0;
  int quiet_cycles = 0;
  int hold_cycles = 0;
  bit hold_done = 0;
  int cycle_cnt = 0;
  logic nxt_valid;
  logic nxt_we;

  // A ROM byte as the block sees it; flags any read of a byte never loaded.
  function automatic logic [7:0] rom_fetch(logic [31:0] a);
    if (a < romsz_q && a < 32'd65536) begin
      if (!rom_loaded[a[15:0]]) touched_blank = 1;
      return rom_img[a[15:0]];
    end
    return 8'h00;
  endfunction

  // Pitch increment per frame in 16.16 fixed point.
  function automatic logic [31:0] pitch_increment(logic [11:0] r);
    longint unsigned ck, sr, den, q;
    ck = (clk_hz_q != 0) ? clk_hz_q : 26'd3579545;
    sr = (srate_q != 0) ? srate_q : 18'd44100;
    den = (64'd4096 - r) * sr;
    q = (ck << FRAC_BITS) / den;
    if (q == 0) q = 1;
    if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    return q[31:0];
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  task automatic sound_reg_write(logic [5:0] r, logic [7:0] v);
    logic [7:0] rising;
    int c;
    logic [2:0] sub;
    if (r > RA_MODE || r <= RA_PORT1) return;
    if (r == RA_SND_PORT2 || r == RA_SND_PORT3) begin
      port_q[r[1:0]] = v;
    end else if (r == RA_KEYON) begin
      rising = v & ~keyon_q;
      keyon_q = v;
      for (c = 0; c < CHANNELS; c++) begin
        flags_q[c][FL_REV] = v[4+c];
        if (rising[c]) begin
          flags_q[c][FL_PLAY] = 1'b1;
          pos_q[c] = flags_q[c][FL_PPCM] ? 32'h0001_0000 : 32'h0;
        end else if (!v[c]) begin
          flags_q[c][FL_PLAY] = 1'b0;
        end
      end
    end else if (r >= RA_CH_FIRST && r < RA_KEYON) begin
      c = (r - RA_CH_FIRST) >> 3;
      sub = r[2:0];
      case (sub)
        SUB_RATE_LO:  rate_q[c][7:0] = v;
        SUB_RATE_HI:  rate_q[c][11:8] = v[3:0];
        SUB_SIZE_LO:  size_q[c][7:0] = v;
        SUB_SIZE_HI:  size_q[c][15:8] = v;
        SUB_START_LO: start_q[c][7:0] = v;
        SUB_START_MD: start_q[c][15:8] = v;
        SUB_START_HI: start_q[c][20:16] = v[4:0];
        default:      vol_q[c] = v[6:0];
      endcase
    end else if (r == RA_LOOP) begin
      for (c = 0; c < CHANNELS; c++) begin
        flags_q[c][FL_LOOP] = v[c];
        flags_q[c][FL_PPCM] = v[4+c];
      end
    end else if (r == RA_PAN01) begin
      pan_q[0] = v[2:0];
      pan_q[1] = v[5:3];
    end else if (r == RA_PAN23) begin
      pan_q[2] = v[2:0];
      pan_q[3] = v[5:3];
    end else if (r == RA_MODE) begin
      mode_q = v[2:0];
    end
  endtask

  task automatic sound_reg_read(logic [5:0] r, output logic [7:0] rd);
    logic [31:0] a;
    int c;
    rd = 8'h00;
    if (r <= RA_PORT1) begin
      rd = port_q[r[1:0]];
      port_q[r[1:0]] = 8'hFF;
    end else if (r == RA_ROMRD) begin
      if (mode_q[0] && romsz_q != 0) begin
        a = start_q[0] + (pos_q[0] >> FRAC_BITS);
        pos_q[0] += 32'h0001_0000;
        rd = rom_fetch(a);
        romreads_live++;
      end
    end else if (r == RA_STATUS) begin
      for (c = 0; c < CHANNELS; c++) rd[c] = flags_q[c][FL_PLAY];
    end
  endtask

  task automatic mix_frame(input logic [12:0] g, inout logic signed [15:0] lft,
                           inout logic signed [15:0] rgt);
    int l, r, s, p, c;
    logic [31:0] off, a;
    longint gl;
    l = 0;
    r = 0;
    if (romsz_q == 0 || !mode_q[1]) return;
    renders_live++;
    for (c = 0; c < CHANNELS; c++) begin
      if (flags_q[c][FL_PLAY]) begin
        if ((pos_q[c] >> FRAC_BITS) >= size_q[c]) begin
          if (flags_q[c][FL_LOOP]) begin
            pos_q[c] = 32'h0;
          end else begin
            flags_q[c][FL_PLAY] = 1'b0;
          end
        end
        if (flags_q[c][FL_PLAY]) begin
          off = pos_q[c] >> FRAC_BITS;
          a = flags_q[c][FL_REV] ? {11'b0, start_q[c]} - off : {11'b0, start_q[c]} + off;
          s = int'(rom_fetch(a));
          if (s >= 128) s -= 256;
          p = s * int'(vol_q[c]);
          l += (p * left_weight[pan_q[c]]) >>> 8;
          r += (p * right_weight[pan_q[c]]) >>> 8;
          pos_q[c] += pitch_increment(rate_q[c]);
        end
      end
    end
    gl = g;
    lft = clip16(longint'(lft) + (longint'(l) * gl) / 256);
    rgt = clip16(longint'(rgt) + (longint'(r) * gl) / 256);
  endtask

  task automatic mixer_predict(input mix_cmd_t cmd, output mix_res_t res);
    logic signed [15:0] lft, rgt;
    res = '0;
    case (cmd.op)
      OP_REG_WR:  sound_reg_write(cmd.reg_addr, cmd.data);
      OP_REG_RD:  sound_reg_read(cmd.reg_addr, res.read_data);
      OP_MAIN_WR: port_q[cmd.reg_addr[0]] = cmd.data;
      OP_MAIN_RD: res.read_data = port_q[{1'b1, cmd.reg_addr[0]}];
      OP_ROM_LD: begin
        rom_img[cmd.rom_addr] = cmd.data;
        rom_loaded[cmd.rom_addr] = 1'b1;
      end
      OP_RENDER: begin
        lft = cmd.mix_left;
        rgt = cmd.mix_right;
        mix_frame(cmd.gain, lft, rgt);
        res.out_left = lft;
        res.out_right = rgt;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Plan building. A command that would read a never-loaded ROM byte is rolled
  // back and replaced by a spare op code, which the block must simply ignore.
  // ---------------------------------------------------------------------------
  task automatic plan_cmd(logic [2:0] op, logic [5:0] ra, logic [7:0] d,
                          logic [15:0] radr = '0, logic signed [15:0] ml = '0,
                          logic signed [15:0] mr = '0, logic [12:0] g = 13'd256);
    plan_slot_t slot;
    logic [31:0] pos_keep [4];
    logic [3:0] flags_keep [4];
    int rl_keep, rr_keep;
    slot = '0;
    slot.cmd = '{op, ra, d, radr, ml, mr, g};
    pos_keep = pos_q;
    flags_keep = flags_q;
    rl_keep = renders_live;
    rr_keep = romreads_live;
    touched_blank = 0;
    mixer_predict(slot.cmd, slot.res);
    if (touched_blank) begin
      pos_q = pos_keep;
      flags_q = flags_keep;
      renders_live = rl_keep;
      romreads_live = rr_keep;
      dropped_cmds++;
      slot.cmd.op = OP_SPARE_A;
      mixer_predict(slot.cmd, slot.res);
    end
    plan_q.push_back(slot);
    total_cmds++;
  endtask

  task automatic plan_cfg(cfg_idx_t idx, logic [25:0] v);
    plan_slot_t slot;
    slot = '0;
    slot.is_cfg = 1'b1;
    slot.cfg_sel = idx;
    slot.cfg_val = v;
    case (idx)
      CFG_CLOCK: clk_hz_q = v[25:0];
      CFG_SRATE: srate_q = v[17:0];
      default:   romsz_q = v[16:0];
    endcase
    plan_q.push_back(slot);
  endtask

  // A complete channel programme followed by its key-on: the common way in.
  task automatic plan_channel_setup(int c);
    logic [5:0] base;
    base = RA_CH_FIRST + 6'(c * 8);
    plan_cmd(OP_REG_WR, base + SUB_RATE_LO, 8'($urandom));
    plan_cmd(OP_REG_WR, base + SUB_RATE_HI, 8'($urandom));
    plan_cmd(OP_REG_WR, base + SUB_SIZE_LO, 8'($urandom_range(64, 1)));
    plan_cmd(OP_REG_WR, base + SUB_SIZE_HI, 8'h00);
    plan_cmd(OP_REG_WR, base + SUB_START_LO, 8'($urandom_range(63)));
    plan_cmd(OP_REG_WR, base + SUB_START_MD, 8'h00);
    plan_cmd(OP_REG_WR, base + SUB_START_HI, 8'h00);
    plan_cmd(OP_REG_WR, base + SUB_VOLUME, 8'($urandom));
    plan_cmd(OP_REG_WR, RA_KEYON, keyon_q | 8'(1 << c) | 8'($urandom_range(255) & 8'hF0));
  endtask

  task automatic plan_random_cmd();
    int pick, c;
    logic [2:0] sub;
    logic [7:0] v;
    pick = $urandom_range(99);
    if (pick < 35) begin
      plan_cmd(OP_RENDER, 6'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 13'($urandom_range(4096)));
    end else if (pick < 42) begin
      plan_channel_setup($urandom_range(3));
    end else if (pick < 58) begin
      c = $urandom_range(3);
      sub = 3'($urandom);
      v = 8'($urandom);
      case (sub)
        SUB_SIZE_LO:  v = 8'($urandom_range(64));
        SUB_SIZE_HI,
        SUB_START_MD,
        SUB_START_HI: if ($urandom_range(7) != 0) v = 8'h00;
        SUB_START_LO: if ($urandom_range(7) != 0) v = 8'($urandom_range(63));
        default: ;
      endcase
      plan_cmd(OP_REG_WR, RA_CH_FIRST + 6'(c * 8) + sub, v);
    end else if (pick < 66) begin
      case ($urandom_range(4))
        0:       plan_cmd(OP_REG_WR, RA_KEYON, 8'($urandom));
        1:       plan_cmd(OP_REG_WR, RA_LOOP, 8'($urandom));
        2:       plan_cmd(OP_REG_WR, RA_PAN01 + 6'($urandom_range(1)), 8'($urandom));
        3:       plan_cmd(OP_REG_WR, RA_MODE, 8'($urandom) | 8'h02);
        default: plan_cmd(OP_REG_WR, 6'($urandom), 8'($urandom));
      endcase
    end else if (pick < 77) begin
      case ($urandom_range(3))
        0:       plan_cmd(OP_REG_RD, 6'($urandom_range(1)), 8'($urandom));
        1:       plan_cmd(OP_REG_RD, RA_STATUS, 8'($urandom));
        2:       plan_cmd(OP_REG_RD, RA_ROMRD, 8'($urandom));
        default: plan_cmd(OP_REG_RD, 6'($urandom), 8'($urandom));
      endcase
    end else if (pick < 84) begin
      plan_cmd(OP_MAIN_WR, 6'($urandom), 8'($urandom));
    end else if (pick < 91) begin
      plan_cmd(OP_MAIN_RD, 6'($urandom), 8'($urandom));
    end else if (pick < 97) begin
      plan_cmd(OP_ROM_LD, 6'($urandom), 8'($urandom),
               ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(ROM_FILL - 1)));
    end else begin
      plan_cmd($urandom_range(1) ? OP_SPARE_A : OP_SPARE_B, 6'($urandom), 8'($urandom));
    end
  endtask

  // Sender and receiver idle rates follow the progress of the run.
  function automatic int sender_idle_pct();
    if (sent_cnt < total_cmds / 3) return 19;
    if (sent_cnt < 2 * total_cmds / 3) return 65;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (sent_cnt < total_cmds / 3) return 65;
    if (sent_cnt < 2 * total_cmds / 3) return 19;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents the head of the plan and holds it until the transaction is
  // taken. Configuration writes wait until every awaited result has arrived and
  // quiet_cycles has reached CFG_QUIET.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        awaited_q.push_back(plan_q[0].res);
        void'(plan_q.pop_front());
        sent_cnt++;
      end
      if (awaited_q.size() == 0) quiet_cycles++;
      else quiet_cycles = 0;
      nxt_valid = in_ch.valid && !in_ch.ready;
      nxt_we = 1'b0;
      if (!nxt_valid && plan_q.size() > 0) begin
        if (plan_q[0].is_cfg) begin
          if (quiet_cycles >= CFG_QUIET) begin
            nxt_we = 1'b1;
            cfg_index <= plan_q[0].cfg_sel;
            cfg_wdata <= plan_q[0].cfg_val;
            void'(plan_q.pop_front());
          end
        end else if ($urandom_range(99) >= sender_idle_pct()) begin
          nxt_valid = 1'b1;
          in_ch.op        <= plan_q[0].cmd.op;
          in_ch.reg_addr  <= plan_q[0].cmd.reg_addr;
          in_ch.data      <= plan_q[0].cmd.data;
          in_ch.rom_addr  <= plan_q[0].cmd.rom_addr;
          in_ch.mix_left  <= plan_q[0].cmd.mix_left;
          in_ch.mix_right <= plan_q[0].cmd.mix_right;
          in_ch.gain      <= plan_q[0].cmd.gain;
        end
      end
      in_ch.valid <= nxt_valid;
      cfg_we <= nxt_we;
    end
  end

  task automatic note_mismatch(string what, int want, int got);
    errors++;
    if (errors <= 10)
      $display("mismatch on result %0d: %s expected %0d, got %0d", results_cnt, what, want, got);
  endtask

  // Monitor: each accepted result is checked against the oldest awaited one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result %0d arrived with nothing awaited", results_cnt);
        end else begin
          if (out_ch.read_data !== awaited_q[0].read_data)
            note_mismatch("read_data", awaited_q[0].read_data, out_ch.read_data);
          if (out_ch.out_left !== awaited_q[0].out_left)
            note_mismatch("out_left", awaited_q[0].out_left, out_ch.out_left);
          if (out_ch.out_right !== awaited_q[0].out_right)
            note_mismatch("out_right", awaited_q[0].out_right, out_ch.out_right);
          void'(awaited_q.pop_front());
        end
        results_cnt++;
      end
      out_ch.ready <= (hold_cycles == 0) && ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  // Once, early on, the receiver refuses results for a long stretch so that the
  // block backs up and has to stall its input.
  always @(posedge clk) begin
    if (!hold_done && results_cnt >= HOLD_AFTER) begin
      hold_cycles <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int i;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.reg_addr = '0;
    in_ch.data = '0;
    in_ch.rom_addr = '0;
    in_ch.mix_left = '0;
    in_ch.mix_right = '0;
    in_ch.gain = '0;
    out_ch.ready = 1'b0;

    // Shadow state as it stands after reset.
    for (i = 0; i < 4; i++) begin
      port_q[i] = 8'hFF;
      rate_q[i] = '0;
      size_q[i] = '0;
      start_q[i] = '0;
      vol_q[i] = '0;
      flags_q[i] = '0;
      pan_q[i] = '0;
      pos_q[i] = '0;
    end
    mode_q = '0;
    keyon_q = '0;
    clk_hz_q = 26'd3579545;
    srate_q = 18'd44100;
    romsz_q = '0;

    // Directed part: ignored and meaningless offsets, port traffic, spare op
    // codes and the pass-through render before any ROM exists.
    plan_cmd(OP_REG_RD, RA_PORT0, 8'h00);
    plan_cmd(OP_MAIN_WR, RA_PORT0, 8'h5A);
    plan_cmd(OP_MAIN_WR, 6'h3F, 8'hA5);
    plan_cmd(OP_REG_RD, RA_PORT0, 8'h00);
    plan_cmd(OP_REG_RD, RA_PORT0, 8'h00);
    plan_cmd(OP_REG_RD, RA_PORT1, 8'h00);
    plan_cmd(OP_REG_WR, RA_SND_PORT2, 8'h00);
    plan_cmd(OP_REG_WR, RA_SND_PORT3, 8'hFF);
    plan_cmd(OP_MAIN_RD, 6'h00, 8'h00);
    plan_cmd(OP_MAIN_RD, 6'h3F, 8'h00);
    plan_cmd(OP_REG_WR, RA_PORT0, 8'h11);
    plan_cmd(OP_REG_WR, 6'h30, 8'h22);
    plan_cmd(OP_REG_WR, 6'h3F, 8'h33);
    plan_cmd(OP_REG_WR, RA_HOLE, 8'h44);
    plan_cmd(OP_REG_RD, RA_HOLE, 8'h00);
    plan_cmd(OP_REG_RD, RA_ROMRD, 8'h00);
    plan_cmd(OP_SPARE_A, 6'h3F, 8'hFF, 16'hFFFF, -16'sd1, -16'sd1, 13'h1FFF);
    plan_cmd(OP_SPARE_B, 6'h00, 8'h00);
    plan_cmd(OP_RENDER, 6'h00, 8'h00, 16'h0, 16'sd32767, -16'sd32768, 13'd4096);
    plan_cmd(OP_ROM_LD, 6'h00, 8'hFF, 16'hFFFF);

    // Sample ROM setup, the first bytes at the sign extremes.
    for (i = 0; i < ROM_FILL; i++)
      plan_cmd(OP_ROM_LD, 6'h00, (i == 0) ? 8'h80 : (i == 1) ? 8'h7F : (i == 2) ? 8'hFF :
               (i == 3) ? 8'h00 : 8'($urandom), 16'(i));
    plan_cfg(CFG_ROMSZ, 26'(ROM_FILL));

    // One loud channel hard left with full gain drives the sum into saturation,
    // then adaptive-PCM start, reverse playback and the ROM read-back port.
    plan_cmd(OP_REG_WR, RA_CH_FIRST + SUB_SIZE_LO, 8'd8);
    plan_cmd(OP_REG_WR, RA_CH_FIRST + SUB_VOLUME, 8'hFF);
    plan_cmd(OP_REG_WR, RA_PAN01, 8'h01);
    plan_cmd(OP_REG_WR, RA_MODE, 8'h03);
    plan_cmd(OP_REG_WR, RA_KEYON, 8'h01);
    plan_cmd(OP_RENDER, 6'h00, 8'h00, 16'h0, -16'sd32768, 16'sd32767, 13'd4096);
    plan_cmd(OP_REG_RD, RA_STATUS, 8'h00);
    plan_cmd(OP_REG_RD, RA_ROMRD, 8'h00);
    plan_cmd(OP_REG_WR, RA_LOOP, 8'hFF);
    plan_cmd(OP_REG_WR, RA_KEYON, 8'h00);
    plan_cmd(OP_REG_WR, RA_KEYON, 8'hF1);
    plan_cmd(OP_RENDER, 6'h00, 8'h00, 16'h0, 16'sd0, 16'sd0, 13'd0);

    // Random phases, each under a different configuration.
    for (i = 0; i < PHASE_ITEMS; i++) plan_random_cmd();
    plan_cfg(CFG_CLOCK, 26'd1);
    plan_cfg(CFG_SRATE, 18'd262143);
    plan_cfg(CFG_ROMSZ, 26'd65536);
    for (i = 0; i < PHASE_ITEMS; i++) plan_random_cmd();
    plan_cfg(CFG_CLOCK, 26'd67108863);
    plan_cfg(CFG_SRATE, 18'd1);
    for (i = 0; i < PHASE_ITEMS; i++) plan_random_cmd();
    plan_cfg(CFG_ROMSZ, 26'd0);
    for (i = 0; i < PHASE_ITEMS / 2; i++) plan_random_cmd();
    plan_cfg(CFG_CLOCK, 26'($urandom_range(20000000, 1000000)));
    plan_cfg(CFG_SRATE, 18'($urandom_range(96000, 8000)));
    plan_cfg(CFG_ROMSZ, 26'($urandom_range(65536, 64)));
    for (i = 0; i < PHASE_ITEMS; i++) plan_random_cmd();
    plan_cfg(CFG_CLOCK, 26'd3579545);
    plan_cfg(CFG_SRATE, 18'd44100);
    plan_cfg(CFG_ROMSZ, 26'd65535);
    for (i = 0; i < PHASE_ITEMS / 2; i++) plan_random_cmd();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (plan_q.size() > 0 || awaited_q.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (awaited_q.size() > 0) errors++;

    $display("run covered %0d commands (%0d live frames, %0d ROM read-backs), %0d results",
             total_cmds, renders_live, romreads_live, results_cnt);
    $display("%0d commands swapped for spare op codes; %0d mismatches", dropped_cmds, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
